// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the multicast receive filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define MRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mrf_pkg.sv =====
// Package with the constants, codes and interface types of the multicast receive filter.
`default_nettype none
package mrf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BITS   = 48;

    localparam int ADDR_W      = 48;
    localparam int ACTION_W    = 2;
    localparam int DTYPE_W     = 2;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [DTYPE_W-1:0] DT_UNICAST   = 2'd0;
    localparam logic [DTYPE_W-1:0] DT_BROADCAST = 2'd1;
    localparam logic [DTYPE_W-1:0] DT_MULTICAST = 2'd2;

    localparam int MODE_SAP_BIT   = 0;
    localparam int MODE_MULTI_BIT = 1;
    localparam int MODE_PHYS_BIT  = 2;
    localparam logic [MODE_W-1:0] MODE_MULTI_ONLY = 3'b010;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED    = 2'd3;

    localparam logic REG_LINK_BOUND   = 1'b0;
    localparam logic REG_PROMISC_MODE = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } mrf_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } mrf_sts_t;

endpackage
`default_nettype wire

// ===== design/multicast_receive_filter_unit.sv =====
// Top level of the multicast receive filter with its stream channels and register port.
//
// The block holds a table of TABLE_DEPTH multicast addresses and takes one
// transaction at a time: add, remove or classify. Every transaction walks the
// whole table through the single read port of the address memory, one entry
// per cycle, and then commits its result to the output register; a result
// waiting in the output register does not hold off the next transaction
// until the following one finishes its walk.
// The table is empty after reset with no clearing pass. The registers
// link_bound (byte address 0) and promisc_mode (byte address 4) should only
// be written while no transaction is in flight.
`default_nettype none
module multicast_receive_filter_unit #(
    parameter int TABLE_DEPTH = mrf_pkg::TABLE_DEPTH,
    parameter int ADDR_BITS   = mrf_pkg::ADDR_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Bits from low: address[47:0], dest_type[49:48], from_promisc_path[50],
    // loopback[51], zero fill[55:52].
    input  wire logic [mrf_pkg::S_TDATA_W-1:0]   s_tdata,
    // Bits from low: action[1:0].
    input  wire logic [mrf_pkg::ACTION_W-1:0]    s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Bits from low: accept[0], status[2:1], zero fill[7:3].
    output logic [mrf_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mrf_pkg::APB_AW-1:0]      paddr,
    input  wire logic [mrf_pkg::APB_DW-1:0]      pwdata,
    output logic [mrf_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);

    mrf_pkg::mrf_cmd_t cmd;
    mrf_pkg::mrf_sts_t sts;

    logic                          link_bound_reg;
    logic [mrf_pkg::MODE_W-1:0]    promisc_mode_reg;
    logic                          cfg_write;
    logic                          accept;
    logic [mrf_pkg::STATUS_W-1:0]  status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_bound_reg   <= 1'b0;
            promisc_mode_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == mrf_pkg::REG_LINK_BOUND) begin
                link_bound_reg <= pwdata[0];
            end else begin
                promisc_mode_reg <= pwdata[mrf_pkg::MODE_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            mrf_pkg::REG_LINK_BOUND:   prdata = mrf_pkg::APB_DW'(link_bound_reg);
            mrf_pkg::REG_PROMISC_MODE: prdata = mrf_pkg::APB_DW'(promisc_mode_reg);
            default:                   prdata = '0;
        endcase
    end

    mrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .action            (s_tuser),
        .address           (s_tdata[47:0]),
        .dest_type         (s_tdata[49:48]),
        .from_promisc_path (s_tdata[50]),
        .loopback          (s_tdata[51]),
        .link_bound        (link_bound_reg),
        .promisc_mode      (promisc_mode_reg),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .accept            (accept),
        .status            (status)
    );

    assign m_tdata = {5'b0, status, accept};

endmodule
`default_nettype wire

// ===== design/mrf_ctrl.sv =====
// Controller state machine that sequences load, table scan and commit of each transaction.
`default_nettype none
module mrf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire mrf_pkg::mrf_sts_t sts,
    output mrf_pkg::mrf_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/mrf_datapath.sv =====
// Datapath with the address table, the scan compare logic, the frame decision and the result register.
`default_nettype none
module mrf_datapath #(
    parameter int TABLE_DEPTH = mrf_pkg::TABLE_DEPTH,
    parameter int ADDR_BITS   = mrf_pkg::ADDR_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mrf_pkg::mrf_cmd_t             cmd,
    output mrf_pkg::mrf_sts_t                  sts,
    input  wire logic [mrf_pkg::ACTION_W-1:0]  action,
    input  wire logic [mrf_pkg::ADDR_W-1:0]    address,
    input  wire logic [mrf_pkg::DTYPE_W-1:0]   dest_type,
    input  wire logic                          from_promisc_path,
    input  wire logic                          loopback,
    input  wire logic                          link_bound,
    input  wire logic [mrf_pkg::MODE_W-1:0]    promisc_mode,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic                               accept,
    output logic [mrf_pkg::STATUS_W-1:0]       status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (ADDR_BITS > mrf_pkg::ADDR_W) ? ADDR_BITS : mrf_pkg::ADDR_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

    logic [ADDR_BITS-1:0] entry_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [ADDR_BITS-1:0]          key_reg;
    logic [mrf_pkg::ACTION_W-1:0]  action_reg;
    logic [mrf_pkg::DTYPE_W-1:0]   dtype_reg;
    logic                          via_promisc_reg;
    logic                          loopback_reg;

    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 cmp_pend_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [ADDR_BITS-1:0] rd_data_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     found_idx_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    logic                          m_tvalid_reg;
    logic                          accept_reg;
    logic [mrf_pkg::STATUS_W-1:0]  status_reg;

    logic [EXT_W-1:0]              addr_ext;
    logic [IDX_W-1:0]              issue_idx;
    logic                          issuing;
    logic                          hit;
    logic                          empty_slot;
    logic                          do_insert;
    logic                          do_delete;
    logic                          decision;
    logic [mrf_pkg::STATUS_W-1:0]  status_next;

    assign addr_ext   = EXT_W'(address);
    assign issue_idx  = issue_cnt_reg[IDX_W-1:0];
    assign issuing    = cmd.scan && (issue_cnt_reg != CNT_END);
    assign hit        = cmp_pend_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == key_reg);
    assign empty_slot = cmp_pend_reg && !valid_reg[cmp_idx_reg];

    assign do_insert = cmd.commit && (action_reg == mrf_pkg::ACT_ADD) && !found_reg
                       && free_found_reg;
    assign do_delete = cmd.commit && (action_reg == mrf_pkg::ACT_REMOVE) && found_reg;

    always_comb begin
        priority if (!link_bound) begin
            decision = 1'b0;
        end else if ((promisc_mode != '0) && !via_promisc_reg
                     && !((promisc_mode == mrf_pkg::MODE_MULTI_ONLY)
                          && (dtype_reg != mrf_pkg::DT_MULTICAST))) begin
            decision = 1'b0;
        end else if (promisc_mode[mrf_pkg::MODE_PHYS_BIT]) begin
            decision = 1'b1;
        end else if ((promisc_mode != '0) && via_promisc_reg && loopback_reg) begin
            decision = 1'b0;
        end else if ((dtype_reg == mrf_pkg::DT_UNICAST)
                     || (dtype_reg == mrf_pkg::DT_BROADCAST)) begin
            decision = 1'b1;
        end else if (dtype_reg == mrf_pkg::DT_MULTICAST) begin
            decision = promisc_mode[mrf_pkg::MODE_MULTI_BIT] || found_reg;
        end else begin
            decision = 1'b0;
        end
    end

    always_comb begin
        status_next = mrf_pkg::STATUS_OK;
        if ((action_reg == mrf_pkg::ACT_ADD) && !found_reg && !free_found_reg) begin
            status_next = mrf_pkg::STATUS_FULL;
        end else if ((action_reg == mrf_pkg::ACT_REMOVE) && !found_reg) begin
            status_next = mrf_pkg::STATUS_NOT_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            entry_mem[free_idx_reg] <= key_reg;
        end
        if (issuing) begin
            rd_data_reg <= entry_mem[issue_idx];
        end
        if (cmd.load) begin
            key_reg         <= addr_ext[ADDR_BITS-1:0];
            action_reg      <= action;
            dtype_reg       <= dest_type;
            via_promisc_reg <= from_promisc_path;
            loopback_reg    <= loopback;
        end
        if (issuing) begin
            cmp_idx_reg <= issue_idx;
        end
        if (hit && !found_reg) begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (empty_slot && !free_found_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.commit) begin
            accept_reg <= (action_reg == mrf_pkg::ACT_CLASSIFY) && decision;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            issue_cnt_reg  <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                issue_cnt_reg  <= '0;
                cmp_pend_reg   <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_pend_reg <= issuing;
                if (issuing) begin
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
                if (empty_slot) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (do_insert) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (do_delete) begin
                valid_reg[found_idx_reg] <= 1'b0;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.scan_done = (issue_cnt_reg == CNT_END) && !cmp_pend_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign accept   = accept_reg;
    assign status   = status_reg;

endmodule
`default_nettype wire

// ===== design/mrf_checker.sv =====
// Port-level checker for the multicast receive filter, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module mrf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mrf_pkg::M_TDATA_W-1:0] m_tdata
);

    `MRF_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `MRF_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second transaction taken during a scan")
    `MRF_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `MRF_ASSERT(a_result_codes, aclk, aresetn, m_tvalid |-> (m_tdata[2:1] != mrf_pkg::STATUS_UNUSED) && !(m_tdata[0] && (m_tdata[2:1] != mrf_pkg::STATUS_OK)), "accept with error status or unused status")

endmodule

bind multicast_receive_filter_unit mrf_checker u_mrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/multicast_receive_filter_unit_test.sv =====
// Self-checking testbench for the multicast receive filter: stream traffic, register setup, checks.
`default_nettype none
module multicast_receive_filter_unit_test;

    localparam logic [mrf_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [mrf_pkg::DTYPE_W-1:0]  DT_OTHER   = 2'd3;
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_ITEMS   = 170;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [mrf_pkg::ACTION_W-1:0] action;
        logic [mrf_pkg::ADDR_W-1:0]   addr;
        logic [mrf_pkg::DTYPE_W-1:0]  dtype;
        logic                         via_promisc;
        logic                         loopback;
    } frame_item_t;

    typedef struct packed {
        logic                         accept;
        logic [mrf_pkg::STATUS_W-1:0] status;
    } verdict_t;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic [mrf_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [mrf_pkg::ACTION_W-1:0]   s_tuser  = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mrf_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [mrf_pkg::APB_AW-1:0]     paddr    = '0;
    logic [mrf_pkg::APB_DW-1:0]     pwdata   = '0;
    logic [mrf_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    multicast_receive_filter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    frame_item_t                frame_queue[$];
    verdict_t                   pending_verdicts[$];
    frame_item_t                offered;
    logic [mrf_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    logic [mrf_pkg::ADDR_W-1:0] table_addr [mrf_pkg::TABLE_DEPTH];
    logic                       table_valid [mrf_pkg::TABLE_DEPTH];
    logic                       bound_q = 1'b0;
    logic [mrf_pkg::MODE_W-1:0] mode_q  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_armed   = 1'b0;
    logic hold_started = 1'b0;
    int hold_left      = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int checked        = 0;
    int delivered      = 0;
    int full_seen      = 0;
    int missing_seen   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < mrf_pkg::TABLE_DEPTH; i++) begin
            table_addr[i]  = '0;
            table_valid[i] = 1'b0;
        end
    end

    // Updates the shadow table and returns the verdict the filter owes for one transaction.
    function automatic verdict_t filter_response(input frame_item_t f);
        verdict_t v;
        int hit;
        int free_slot;
        v = '0;
        hit = -1;
        free_slot = -1;
        for (int i = mrf_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (table_valid[i] && table_addr[i] == f.addr) hit = i;
            if (!table_valid[i]) free_slot = i;
        end
        case (f.action)
            mrf_pkg::ACT_ADD: begin
                if (hit < 0) begin
                    if (free_slot >= 0) begin
                        table_addr[free_slot]  = f.addr;
                        table_valid[free_slot] = 1'b1;
                    end else begin
                        v.status = mrf_pkg::STATUS_FULL;
                    end
                end
            end
            mrf_pkg::ACT_REMOVE: begin
                if (hit >= 0) table_valid[hit] = 1'b0;
                else v.status = mrf_pkg::STATUS_NOT_FOUND;
            end
            mrf_pkg::ACT_CLASSIFY: begin
                if (!bound_q)
                    v.accept = 1'b0;
                else if (mode_q != '0 && !f.via_promisc &&
                         !(mode_q == mrf_pkg::MODE_MULTI_ONLY &&
                           f.dtype != mrf_pkg::DT_MULTICAST))
                    v.accept = 1'b0;
                else if (mode_q[mrf_pkg::MODE_PHYS_BIT])
                    v.accept = 1'b1;
                else if (mode_q != '0 && f.via_promisc && f.loopback)
                    v.accept = 1'b0;
                else if (f.dtype == mrf_pkg::DT_UNICAST || f.dtype == mrf_pkg::DT_BROADCAST)
                    v.accept = 1'b1;
                else if (f.dtype == mrf_pkg::DT_MULTICAST)
                    v.accept = mode_q[mrf_pkg::MODE_MULTI_BIT] || (hit >= 0);
                else
                    v.accept = 1'b0;
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic frame_item_t make_frame(input logic [mrf_pkg::ACTION_W-1:0] action,
                                               input logic [mrf_pkg::ADDR_W-1:0] addr,
                                               input logic [mrf_pkg::DTYPE_W-1:0] dtype,
                                               input logic via_promisc,
                                               input logic loopback);
        frame_item_t f;
        f.action      = action;
        f.addr        = addr;
        f.dtype       = dtype;
        f.via_promisc = via_promisc;
        f.loopback    = loopback;
        return f;
    endfunction

    task automatic write_reg(input logic reg_index, input logic [mrf_pkg::MODE_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= mrf_pkg::APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == mrf_pkg::REG_LINK_BOUND) bound_q = value[0];
        else mode_q = value;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (frame_queue.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
        repeat (mrf_pkg::TABLE_DEPTH + 4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_verdicts.push_back(filter_response(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = frame_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, offered.loopback, offered.via_promisc,
                                 offered.dtype, offered.addr};
                    s_tuser  <= offered.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        verdict_t exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %h", m_tdata);
            end else begin
                exp_v = pending_verdicts.pop_front();
                checked++;
                if (exp_v.accept) delivered++;
                if (exp_v.status == mrf_pkg::STATUS_FULL) full_seen++;
                if (exp_v.status == mrf_pkg::STATUS_NOT_FOUND) missing_seen++;
                if (m_tdata[0] !== exp_v.accept || m_tdata[2:1] !== exp_v.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: accept exp %0b got %0b, status exp %0d got %0d",
                                 exp_v.accept, m_tdata[0], exp_v.status, m_tdata[2:1]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        frame_item_t f;
        logic [63:0] wide;
        int roll;
        for (int i = 0; i < POOL_SIZE; i++) begin
            wide = {$urandom, $urandom};
            addr_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : wide[mrf_pkg::ADDR_W-1:0];
        end
        send_idle_pct = 36;
        recv_idle_pct = 81;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(mrf_pkg::REG_LINK_BOUND, 3'd1);
        write_reg(mrf_pkg::REG_PROMISC_MODE, 3'd0);
        frame_queue.push_back(make_frame(mrf_pkg::ACT_ADD, addr_pool[0],
                                         mrf_pkg::DT_UNICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_ADD, addr_pool[1],
                                         DT_OTHER, 1'b1, 1'b1));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_ADD, addr_pool[1],
                                         mrf_pkg::DT_UNICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_REMOVE, addr_pool[20],
                                         mrf_pkg::DT_UNICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_CLASSIFY, addr_pool[1],
                                         mrf_pkg::DT_MULTICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_CLASSIFY, addr_pool[20],
                                         mrf_pkg::DT_MULTICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_CLASSIFY, addr_pool[0],
                                         mrf_pkg::DT_UNICAST, 1'b0, 1'b1));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_CLASSIFY, addr_pool[1],
                                         mrf_pkg::DT_BROADCAST, 1'b1, 1'b1));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_CLASSIFY, addr_pool[0],
                                         DT_OTHER, 1'b1, 1'b0));
        frame_queue.push_back(make_frame(ACT_UNUSED, addr_pool[1],
                                         mrf_pkg::DT_MULTICAST, 1'b1, 1'b1));
        for (int i = 2; i < mrf_pkg::TABLE_DEPTH; i++)
            frame_queue.push_back(make_frame(mrf_pkg::ACT_ADD, addr_pool[i],
                                             mrf_pkg::DT_MULTICAST, 1'b0, 1'b0));
        frame_queue.push_back(make_frame(mrf_pkg::ACT_ADD, addr_pool[16],
                                         mrf_pkg::DT_MULTICAST, 1'b0, 1'b0));
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                send_idle_pct = 81;
                recv_idle_pct = 36;
            end
            if (p == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_armed    = 1'b1;
            end
            write_reg(mrf_pkg::REG_LINK_BOUND, (p == 0 || p == 9) ? 3'd0 : 3'd1);
            write_reg(mrf_pkg::REG_PROMISC_MODE,
                      (p == 0) ? 3'd7 : (p == 9) ? 3'd0 : mrf_pkg::MODE_W'(p - 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                wide = {$urandom, $urandom};
                f.action = (roll < 28) ? mrf_pkg::ACT_ADD : (roll < 48) ? mrf_pkg::ACT_REMOVE :
                           (roll < 96) ? mrf_pkg::ACT_CLASSIFY : ACT_UNUSED;
                f.addr = ($urandom_range(7) == 0) ? wide[mrf_pkg::ADDR_W-1:0]
                                                  : addr_pool[$urandom_range(POOL_SIZE - 1)];
                f.dtype = $urandom_range(1) ? mrf_pkg::DT_MULTICAST
                                            : mrf_pkg::DTYPE_W'($urandom_range(3));
                f.via_promisc = 1'($urandom_range(1));
                f.loopback = 1'($urandom_range(1));
                frame_queue.push_back(f);
            end
            wait_drained();
        end

        $display("Covered %0d transactions over eleven register settings: %0d frames delivered,",
                 checked, delivered);
        $display("%0d table-full and %0d not-found responses, %0d mismatches.",
                 full_seen, missing_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire
